FILE: hw/rtl/heightmap_bilinear_terrain_quads_defines.svh
// assertion macros for the terrain quad block
// no dependencies
`ifndef HEIGHTMAP_BILINEAR_TERRAIN_QUADS_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_TERRAIN_QUADS_DEFINES_SVH
// implication checked on every clock edge outside reset
`define HBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define HBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: hw/rtl/hbt_pkg.sv
// shared constants and types for the terrain quad block
// no dependencies
`timescale 1ns / 1ps
package hbt_pkg;
	localparam int MAP_DIM_DEF  = 64;
	localparam int GRID_MAX_DEF = 256;
	localparam logic [7:0] GRID_RST = 8'd100;
	localparam logic [6:0] MAP_RST  = 7'd50;
	localparam logic [0:0] REG_GRID = 1'b0;
	localparam logic [0:0] REG_MAP  = 1'b1;
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUAD  = 1'b1;

	// unsigned divider request and reply
	typedef struct packed {
		logic        start;
		logic [47:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [47:0] quo;
	} div_rsp_t;
endpackage

FILE: hw/rtl/hbt_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// uses hbt_pkg
`timescale 1ns / 1ps
module hbt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  hbt_pkg::div_req_t req,
	output hbt_pkg::div_rsp_t rsp
);
	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], quo_q[47]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

FILE: hw/rtl/heightmap_bilinear_terrain_quads.sv
// terrain quad block: height map store, bilinear resampling and face normals
// uses hbt_pkg and hbt_div
// cell writes and out-of-grid requests are taken from idle; a quad request runs ten divisions on the
// shared divider, fetch and multiply, and two root passes, then six vertex transfers that stall on m_tready
// reset clears control state and runs a clearing pass over the store
`timescale 1ns / 1ps
module heightmap_bilinear_terrain_quads #(
	parameter int MAP_DIM  = hbt_pkg::MAP_DIM_DEF,
	parameter int GRID_MAX = hbt_pkg::GRID_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd, map_row, map_col, cell_height, quad_row, quad_col, zero pad
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, vertex_index, zero pad
	output logic [119:0] m_tdata,
	output logic        m_tlast
);
	localparam int AW = $clog2(MAP_DIM);
	localparam int SW = 2 * AW;
	localparam int DEPTH = 1 << SW;

	typedef enum logic [11:0] {
		ST_CLEAR = 12'b000000000001,
		ST_IDLE  = 12'b000000000010,
		ST_DIVS  = 12'b000000000100,
		ST_DIVW  = 12'b000000001000,
		ST_FETCH = 12'b000000010000,
		ST_MUL   = 12'b000000100000,
		ST_CRS   = 12'b000001000000,
		ST_SQRT  = 12'b000010000000,
		ST_NDIVS = 12'b000100000000,
		ST_NDIVW = 12'b001000000000,
		ST_OUT   = 12'b010000000000,
		ST_SPARE = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [SW:0]  clr_q;
	logic [15:0]  mem [DEPTH];
	logic [15:0]  rd_q;
	logic [SW-1:0] rd_addr;
	logic [7:0]   grid_q;
	logic [6:0]   map_q;
	logic [8:0]   gs;
	logic [6:0]   ms;
	logic [7:0]   qr_q, qc_q;

	// input fields
	logic        in_cmd;
	logic [5:0]  in_mr, in_mc;
	logic [15:0] in_h;
	logic [7:0]  in_qr, in_qc;
	assign in_cmd = s_tdata[0];
	assign in_mr  = s_tdata[6:1];
	assign in_mc  = s_tdata[12:7];
	assign in_h   = s_tdata[28:13];
	assign in_qr  = s_tdata[36:29];
	assign in_qc  = s_tdata[44:37];

	always_comb begin
		gs = (grid_q > 8'(GRID_MAX > 255 ? 255 : GRID_MAX)) ?
			9'(GRID_MAX > 255 ? 255 : GRID_MAX) : {1'b0, grid_q};
		ms = (map_q < 7'd2) ? 7'd2 : map_q;
		if (32'(ms) > MAP_DIM) ms = 7'(MAP_DIM);
	end

	// coordinates: four axis values (row r, r+1, col c, c+1)
	logic [1:0]  ci_q;
	logic [47:0] u_q [4];
	hbt_pkg::div_req_t dreq;
	hbt_pkg::div_rsp_t drsp;
	hbt_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// per-vertex resampling
	logic [1:0]  vi_q;
	logic [2:0]  fi_q;
	logic signed [15:0] cell_q [4];
	logic signed [63:0] acc_q;
	logic [1:0]  mi_q;
	logic signed [15:0] py_q [4];
	logic [2:0]  mstep_q;
	logic signed [33:0] part_q;

	// normals
	logic        ti_q;
	logic signed [31:0] cr_q [2][3];
	logic [63:0] l2_q;
	logic [63:0] sx_q, sr_q, sb_q;
	logic [31:0] len_q;
	logic [1:0]  ni_q;
	logic signed [15:0] nrm_q [2][3];
	logic [2:0]  oi_q;

	logic [47:0] ux, uz;
	logic [AW:0] lx, lz, rx, rz;
	logic [16:0] fx, fz, wx, wz;
	assign ux = u_q[{1'b0, vi_q[1]}];
	assign uz = u_q[{1'b1, vi_q[0]}];
	always_comb begin
		lx = (AW+1)'(ux[47:16] + 32'(fi_q[1]));
		lz = (AW+1)'(uz[47:16] + 32'(fi_q[0]));
		rx = lx;
		rz = lz;
		fx = {1'b0, ux[15:0]};
		fz = {1'b0, uz[15:0]};
		wx = mi_q[1] ? fx : 17'h10000 - fx;
		wz = mi_q[0] ? fz : 17'h10000 - fz;
	end
	assign rd_addr = {rx[AW-1:0], rz[AW-1:0]};

	// corner positions for output vertices
	function automatic logic signed [17:0] pxz(input logic [8:0] g, input logic [8:0] s);
		return 18'(signed'({1'b0, g, 8'd0})) - 18'(signed'({2'b0, s, 7'd0}));
	endfunction
	logic [8:0] gr0, gr1, gc0, gc1;
	assign gr0 = {1'b0, qr_q};
	assign gr1 = gr0 + 9'd1;
	assign gc0 = {1'b0, qc_q};
	assign gc1 = gc0 + 9'd1;

	// cross products: tri A uses p0,p1,p2; tri B uses p1,p3,p2
	// A: v1=(0,y1-y0,256) v2=(256,y2-y0,0)
	// B: v1=(256,y3-y1,0) v2=(256,y2-y1,-256)
	logic signed [17:0] da1, da2, db1, db2;
	assign da1 = 18'(py_q[1]) - 18'(py_q[0]);
	assign da2 = 18'(py_q[2]) - 18'(py_q[0]);
	assign db1 = 18'(py_q[3]) - 18'(py_q[1]);
	assign db2 = 18'(py_q[2]) - 18'(py_q[1]);

	// sqrt step
	logic [63:0] s_sum;
	assign s_sum = sr_q + sb_q;

	logic [15:0] ncmp_abs;
	logic signed [31:0] ncomp;
	assign ncomp = cr_q[ti_q][ni_q];
	logic [31:0] nmag;
	assign nmag = ncomp[31] ? 32'(-ncomp) : 32'(ncomp);

	always_comb begin
		dreq = '0;
		if (state_q == ST_DIVS) begin
			dreq.start = 1'b1;
			dreq.num = 48'({(ci_q[1] ? gc0 : gr0) + 9'(ci_q[0])} * 48'(ms - 7'd1)) << 16;
			dreq.den = 32'(gs) + 32'd1;
		end else if (state_q == ST_NDIVS) begin
			dreq.start = 1'b1;
			dreq.num = (48'(nmag) << 25) + 48'(len_q);
			dreq.den = {len_q[30:0], 1'b0};
		end
	end
	assign ncmp_abs = (drsp.quo > 48'd16384) ? 16'd16384 : drsp.quo[15:0];

	// memory
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR)
			mem[clr_q[SW-1:0]] <= '0;
		else if (s_tvalid && s_tready && in_cmd == hbt_pkg::CMD_WRITE &&
			32'(in_mr) < MAP_DIM && 32'(in_mc) < MAP_DIM)
			mem[{AW'(in_mr), AW'(in_mc)}] <= in_h;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= hbt_pkg::GRID_RST;
			map_q  <= hbt_pkg::MAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hbt_pkg::REG_GRID: grid_q <= cfg_data;
				hbt_pkg::REG_MAP:  map_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			ci_q <= '0; vi_q <= '0; fi_q <= '0; mi_q <= '0; mstep_q <= '0;
			ti_q <= 1'b0; ni_q <= '0; oi_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (SW+1)'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_tvalid && in_cmd == hbt_pkg::CMD_QUAD &&
					{1'b0, in_qr} < gs && {1'b0, in_qc} < gs) begin
					ci_q <= '0;
					state_q <= ST_DIVS;
				end
				ST_DIVS: state_q <= ST_DIVW;
				ST_DIVW: if (drsp.done) begin
					ci_q <= ci_q + 2'd1;
					if (ci_q == 2'd3) begin
						vi_q <= '0; fi_q <= '0;
						state_q <= ST_FETCH;
					end else state_q <= ST_DIVS;
				end
				ST_FETCH: begin
					fi_q <= fi_q + 3'd1;
					if (fi_q == 3'd4) begin
						mi_q <= '0; mstep_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mstep_q == 3'd1) begin
						mstep_q <= '0;
						mi_q <= mi_q + 2'd1;
						if (mi_q == 2'd3) begin
							vi_q <= vi_q + 2'd1;
							fi_q <= '0;
							state_q <= (vi_q == 2'd3) ? ST_CRS : ST_FETCH;
						end
					end else mstep_q <= mstep_q + 3'd1;
				end
				ST_CRS: begin
					ti_q <= 1'b0; mstep_q <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (mstep_q != 3'd2) mstep_q <= mstep_q + 3'd1;
					else if (sb_q == 64'd1) begin
						ni_q <= '0;
						state_q <= ST_NDIVS;
					end
				end
				ST_NDIVS: state_q <= ST_NDIVW;
				ST_NDIVW: if (drsp.done) begin
					ni_q <= ni_q + 2'd1;
					if (ni_q == 2'd2) begin
						if (ti_q) begin
							oi_q <= '0;
							state_q <= ST_OUT;
						end else begin
							ti_q <= 1'b1; mstep_q <= '0;
							state_q <= ST_SQRT;
						end
					end else state_q <= ST_NDIVS;
				end
				ST_OUT: if (m_tready) begin
					oi_q <= oi_q + 3'd1;
					if (oi_q == 3'd5) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			qr_q <= in_qr;
			qc_q <= in_qc;
		end
		if (state_q == ST_DIVW && drsp.done) u_q[ci_q] <= drsp.quo;
		if (state_q == ST_FETCH) begin
			if (fi_q != 3'd0) cell_q[fi_q[1:0] - 2'd1] <= rd_q;
			if (fi_q == 3'd0) acc_q <= '0;
		end
		if (state_q == ST_MUL) begin
			if (mstep_q == 3'd0)
				part_q <= 34'(signed'({1'b0, wx})) * 34'(cell_q[mi_q]);
			else
				acc_q <= acc_q + 64'(part_q) * 64'(signed'({1'b0, wz}));
			if (mstep_q == 3'd1 && mi_q == 2'd3)
				py_q[vi_q] <= 16'((acc_q + 64'(part_q) * 64'(signed'({1'b0, wz})) +
					(64'sd1 <<< 31)) >>> 32);
		end
		if (state_q == ST_CRS) begin
			// A: (y1-y0)*0-256*(y2-y0), 256*256-0, 0-(y1-y0)*256 all /256
			cr_q[0][0] <= -32'(da2);
			cr_q[0][1] <= 32'sd256;
			cr_q[0][2] <= -32'(da1);
			// B: (y3-y1)*(-256)-0, 0+256*256, 256*(y2-y1)-(y3-y1)*256 all /256
			cr_q[1][0] <= -32'(db1);
			cr_q[1][1] <= 32'sd256;
			cr_q[1][2] <= 32'(db2) - 32'(db1);
		end
		if (state_q == ST_SQRT) begin
			if (mstep_q == 3'd0) begin
				l2_q <= 64'(cr_q[ti_q][0]) * 64'(cr_q[ti_q][0]) +
					64'(cr_q[ti_q][1]) * 64'(cr_q[ti_q][1]) +
					64'(cr_q[ti_q][2]) * 64'(cr_q[ti_q][2]);
			end else if (mstep_q == 3'd1) begin
				sx_q <= l2_q << 20;
				sr_q <= '0;
				sb_q <= 64'd1 << 62;
			end else begin
				if (sx_q >= s_sum) begin
					sx_q <= sx_q - s_sum;
					sr_q <= (sr_q >> 1) + sb_q;
				end else sr_q <= sr_q >> 1;
				sb_q <= sb_q >> 2;
				len_q <= 32'((sx_q >= s_sum) ? (sr_q >> 1) + sb_q : sr_q >> 1);
			end
		end
		if (state_q == ST_NDIVW && drsp.done)
			nrm_q[ti_q][ni_q] <= ncomp[31] ? -16'(ncmp_abs) : 16'(ncmp_abs);
	end

	// output mux
	logic [1:0] pk;
	always_comb begin
		unique case (oi_q)
			3'd0: pk = 2'd0;
			3'd1: pk = 2'd1;
			3'd2: pk = 2'd2;
			3'd3: pk = 2'd1;
			3'd4: pk = 2'd3;
			default: pk = 2'd2;
		endcase
	end
	logic signed [17:0] ox, oz;
	logic [18:0] vidx;
	logic tsel;
	assign ox = pxz(pk[1] ? gr1 : gr0, gs);
	assign oz = pxz(pk[0] ? gc1 : gc0, gs);
	assign vidx = 19'((32'(qr_q) * 32'(gs) + 32'(qc_q)) * 32'd6 + 32'(oi_q));
	assign tsel = (oi_q >= 3'd3);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tlast  = (oi_q == 3'd5);
	assign m_tdata  = {5'd0, vidx, nrm_q[tsel][2], nrm_q[tsel][1], nrm_q[tsel][0],
		oz[15:0], py_q[pk], ox[15:0]};
endmodule

FILE: hw/rtl/hbt_checker.sv
// port-level checks for the terrain quad block, bound to the top level
// uses heightmap_bilinear_terrain_quads_defines.svh
`timescale 1ns / 1ps
`include "heightmap_bilinear_terrain_quads_defines.svh"
module hbt_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tlast
);
	`HBT_ASSERT_IMP(no_take_while_out, clk, arst_n, m_tvalid, !s_tready)
	`HBT_ASSERT_NEXT(idle_after_last, clk, arst_n, m_tvalid && m_tready && m_tlast, !m_tvalid)
	`HBT_ASSERT_NEXT(hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
endmodule

bind heightmap_bilinear_terrain_quads hbt_checker u_hbt_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast)
);
